### rtl/dscc_pkg.sv
// Shared types, constants and helpers for the dust sample check and convert block.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dscc_pkg;

   // Converter sample width on the request side.
   localparam int SAMPLE_BITS = 12;
   // Fixed widths of the register and result fields.
   localparam int CFG_BITS    = 16;
   localparam int LIMIT_BITS  = 8;
   localparam int RAW_BITS    = 12;
   localparam int COUNT_BITS  = 8;
   localparam int OUT_BITS    = 16;
   localparam int INDEX_BITS  = 3;

   // Microvolt-style scaling from mV per mg/m3 to ug/m3.
   localparam int SCALE_BITS  = 10;
   localparam logic [SCALE_BITS-1:0] DUST_SCALE = SCALE_BITS'(1000);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

   // The shared divider must hold the larger of the two dividends.
   localparam int VOLT_PROD_BITS = SAMPLE_BITS + CFG_BITS;
   localparam int DUST_PROD_BITS = OUT_BITS + SCALE_BITS;
   localparam int DIV_BITS = (VOLT_PROD_BITS > DUST_PROD_BITS) ? VOLT_PROD_BITS
                                                               : DUST_PROD_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

   // Result status codes.
   typedef enum logic [1:0] {
      ST_VALID        = 2'd0,
      ST_FS_ZERO      = 2'd1,
      ST_DISCONNECTED = 2'd2
   } status_type;

   // Configuration register indexes.
   typedef enum logic [INDEX_BITS-1:0] {
      REG_FULL_SCALE    = 3'd0,
      REG_REFERENCE_MV  = 3'd1,
      REG_ZERO_DUST_MV  = 3'd2,
      REG_SLOPE         = 3'd3,
      REG_LOW_LIMIT     = 3'd4,
      REG_HIGH_LIMIT    = 3'd5,
      REG_MIN_DIFF      = 3'd6,
      REG_FAILURE_LIMIT = 3'd7
   } reg_index_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [CFG_BITS-1:0]   full_scale_code;
      logic [CFG_BITS-1:0]   reference_mv;
      logic [CFG_BITS-1:0]   zero_dust_mv;
      logic [CFG_BITS-1:0]   slope_mv_per_mg;
      logic [CFG_BITS-1:0]   low_limit;
      logic [CFG_BITS-1:0]   high_limit;
      logic [CFG_BITS-1:0]   min_difference;
      logic [LIMIT_BITS-1:0] failure_limit;
   } cfg_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DECIDE,
      S_START_V,
      S_DIV_V,
      S_MUL_D,
      S_START_D,
      S_DIV_D,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic check;
      logic mul_volt;
      logic div_start;
      logic div_dust;
      logic take_volt;
      logic mul_dust;
      logic take_dust;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic convert;
      logic div_done;
      logic dust_needed;
      logic out_free;
   } sts_type;

   // Saturate a divider quotient to the 16-bit result range.
   function automatic logic [OUT_BITS-1:0] sat16(input logic [DIV_BITS-1:0] q);
      logic [OUT_BITS-1:0] r;
      if (|q[DIV_BITS-1:OUT_BITS]) begin
         r = '1;
      end else begin
         r = q[OUT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/dscc_regs.sv
// Configuration register file for the dust sample check and convert block.
// Depends on dscc_pkg for the register index codes and the cfg_type struct.
`timescale 1ns / 1ps
`default_nettype none

module dscc_regs (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dscc_pkg::INDEX_BITS-1:0]   csr_index,
   input  wire logic [dscc_pkg::CFG_BITS-1:0]     csr_wdata,
   output dscc_pkg::cfg_type                      cfg
);
   import dscc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index and update one register per write word.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_FULL_SCALE:    cfg_in.full_scale_code = csr_wdata;
            REG_REFERENCE_MV:  cfg_in.reference_mv    = csr_wdata;
            REG_ZERO_DUST_MV:  cfg_in.zero_dust_mv    = csr_wdata;
            REG_SLOPE:         cfg_in.slope_mv_per_mg = csr_wdata;
            REG_LOW_LIMIT:     cfg_in.low_limit       = csr_wdata;
            REG_HIGH_LIMIT:    cfg_in.high_limit      = csr_wdata;
            REG_MIN_DIFF:      cfg_in.min_difference  = csr_wdata;
            REG_FAILURE_LIMIT: cfg_in.failure_limit   = csr_wdata[LIMIT_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale_code <= CFG_BITS'(4095);
         cfg_ff.reference_mv    <= CFG_BITS'(3300);
         cfg_ff.zero_dust_mv    <= CFG_BITS'(600);
         cfg_ff.slope_mv_per_mg <= CFG_BITS'(500);
         cfg_ff.low_limit       <= CFG_BITS'(20);
         cfg_ff.high_limit      <= CFG_BITS'(4075);
         cfg_ff.min_difference  <= CFG_BITS'(20);
         cfg_ff.failure_limit   <= LIMIT_BITS'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/dscc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on dscc_pkg for DIV_BITS and the counter width.
`timescale 1ns / 1ps
`default_nettype none

module dscc_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [dscc_pkg::DIV_BITS-1:0]   dividend,
   input  wire logic [dscc_pkg::CFG_BITS-1:0]   divisor,
   output logic                                 done,
   output logic [dscc_pkg::DIV_BITS-1:0]        quotient
);
   import dscc_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic [CFG_BITS-1:0]     rem_ff, rem_in;
   logic [CFG_BITS-1:0]     dsr_ff, dsr_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [CFG_BITS:0]       trial;
   logic                    fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign trial = {rem_ff, quo_ff[DIV_BITS-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_BITS'(DIV_BITS - 1);
         rem_in   = '0;
         dsr_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? CFG_BITS'(trial - {1'b0, dsr_ff}) : trial[CFG_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags are reset; the working words are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
   end

endmodule

`default_nettype wire

### rtl/dscc_dp.sv
// Datapath: plausibility check, failure counter, multipliers, output register.
// Depends on dscc_pkg and instantiates dscc_div.
`timescale 1ns / 1ps
`default_nettype none

module dscc_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dscc_pkg::cfg_type                  cfg,
   input  wire dscc_pkg::cmd_type                  cmd,
   output dscc_pkg::sts_type                       sts,
   input  wire logic [dscc_pkg::SAMPLE_BITS-1:0]   req_sample_led_off,
   input  wire logic [dscc_pkg::SAMPLE_BITS-1:0]   req_sample_led_on,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output dscc_pkg::status_type                    rsp_status,
   output logic [dscc_pkg::RAW_BITS-1:0]           rsp_raw_code,
   output logic                                    rsp_suspect,
   output logic [dscc_pkg::COUNT_BITS-1:0]         rsp_failure_count,
   output logic [dscc_pkg::OUT_BITS-1:0]           rsp_voltage_mv,
   output logic [dscc_pkg::OUT_BITS-1:0]           rsp_dust_ug_m3
);
   import dscc_pkg::*;

   // Captured request word.
   logic [SAMPLE_BITS-1:0] off_ff, on_ff;
   // Working result.
   status_type             status_ff, status_in;
   logic                   suspect_ff, suspect_in;
   logic [RAW_BITS-1:0]    raw_ff, raw_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [OUT_BITS-1:0]    volt_ff, dust_ff;
   logic [DIV_BITS-1:0]    product_ff;
   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             out_status_ff;
   logic [RAW_BITS-1:0]    out_raw_ff;
   logic                   out_suspect_ff;
   logic [COUNT_BITS-1:0]  out_count_ff;
   logic [OUT_BITS-1:0]    out_volt_ff, out_dust_ff;

   logic [SAMPLE_BITS-1:0] delta;
   logic                   suspect_c;
   logic [COUNT_BITS-1:0]  count_inc;
   logic [OUT_BITS-1:0]    volt_excess;
   logic                   div_done;
   logic [DIV_BITS-1:0]    quotient;
   logic [CFG_BITS-1:0]    divisor;

   // Plausibility check on the captured samples.
   assign delta     = (on_ff > off_ff) ? (on_ff - off_ff) : (off_ff - on_ff);
   assign suspect_c = (CFG_BITS'(on_ff) <= cfg.low_limit)
                   || (CFG_BITS'(on_ff) >= cfg.high_limit)
                   || (CFG_BITS'(delta) < cfg.min_difference);
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

   // Result of the check step: status, suspect flag and new counter value.
   always_comb begin
      status_in  = status_ff;
      suspect_in = suspect_ff;
      raw_in     = raw_ff;
      count_in   = count_ff;
      if (cmd.check) begin
         if (cfg.full_scale_code == '0) begin
            status_in  = ST_FS_ZERO;
            suspect_in = 1'b0;
            raw_in     = '0;
         end else begin
            raw_in     = RAW_BITS'(on_ff);
            suspect_in = suspect_c;
            if (suspect_c) begin
               count_in  = count_inc;
               status_in = (count_inc >= cfg.failure_limit) ? ST_DISCONNECTED : ST_VALID;
            end else begin
               count_in  = '0;
               status_in = ST_VALID;
            end
         end
      end
   end

   // The shared divider takes full scale first and the slope second.
   assign divisor = cmd.div_dust ? cfg.slope_mv_per_mg : cfg.full_scale_code;

   dscc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (product_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign volt_excess = volt_ff - cfg.zero_dust_mv;

   // Status back to the controller.
   always_comb begin
      sts.convert     = (status_ff == ST_VALID);
      sts.div_done    = div_done;
      sts.dust_needed = (cfg.slope_mv_per_mg != '0) && (volt_ff > cfg.zero_dust_mv);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Output valid: set on load, cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state: failure counter and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      suspect_ff <= suspect_in;
      raw_ff     <= raw_in;
      if (cmd.capture) begin
         off_ff <= req_sample_led_off;
         on_ff  <= req_sample_led_on;
      end
      if (cmd.check) begin
         volt_ff <= '0;
         dust_ff <= '0;
      end
      if (cmd.mul_volt) begin
         product_ff <= DIV_BITS'(on_ff) * DIV_BITS'(cfg.reference_mv);
      end
      if (cmd.mul_dust) begin
         product_ff <= DIV_BITS'(volt_excess) * DIV_BITS'(DUST_SCALE);
      end
      if (cmd.take_volt) begin
         volt_ff <= sat16(quotient);
      end
      if (cmd.take_dust) begin
         dust_ff <= sat16(quotient);
      end
   end

   // Output register, loaded once per finished item.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff  <= status_ff;
         out_raw_ff     <= raw_ff;
         out_suspect_ff <= suspect_ff;
         out_count_ff   <= count_ff;
         out_volt_ff    <= volt_ff;
         out_dust_ff    <= dust_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_raw_code      = out_raw_ff;
   assign rsp_suspect       = out_suspect_ff;
   assign rsp_failure_count = out_count_ff;
   assign rsp_voltage_mv    = out_volt_ff;
   assign rsp_dust_ug_m3    = out_dust_ff;

endmodule

`default_nettype wire

### rtl/dscc_ctrl.sv
// Controller state machine that steps the datapath through one item.
// Depends on dscc_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module dscc_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dscc_pkg::sts_type sts,
   output dscc_pkg::cmd_type  cmd
);
   import dscc_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.convert) begin
               cmd.mul_volt = 1'b1;
               state_in     = S_START_V;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_START_V: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_V;
         end
         S_DIV_V: begin
            if (sts.div_done) begin
               cmd.take_volt = 1'b1;
               state_in      = S_MUL_D;
            end
         end
         S_MUL_D: begin
            if (sts.dust_needed) begin
               cmd.mul_dust = 1'b1;
               state_in     = S_START_D;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_START_D: begin
            cmd.div_start = 1'b1;
            cmd.div_dust  = 1'b1;
            state_in      = S_DIV_D;
         end
         S_DIV_D: begin
            cmd.div_dust = 1'b1;
            if (sts.div_done) begin
               cmd.take_dust = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

### rtl/dust_sample_check_convert_core.sv
// Top level of the dust sample check and convert block.
// Depends on dscc_pkg and instantiates dscc_regs, dscc_ctrl and dscc_dp.
//
//   channel   direction  handshake              word
//   req_      in         req_valid / req_ready  LED-off and LED-on samples
//   rsp_      out        rsp_valid / rsp_ready  status, raw, suspect, count, mV, ug/m3
//   csr_      in         csr_valid / csr_ready  register index and write data
//
// The time from acceptance to the next acceptance is set mostly by the shared
// restoring divider, at one quotient bit per cycle and up to two divisions per
// item. Items flagged as disconnected or full scale zero skip both divisions,
// and items with no dust division take only the voltage division.
// Reset is synchronous and active high; it restores the register defaults and
// clears the failure counter. A result waiting in the output register does not
// stop the next request word being taken; the block stalls only when a second
// result is ready before the first has gone.
`timescale 1ns / 1ps
`default_nettype none

module dust_sample_check_convert_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [dscc_pkg::SAMPLE_BITS-1:0]   req_sample_led_off,
   input  wire logic [dscc_pkg::SAMPLE_BITS-1:0]   req_sample_led_on,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output dscc_pkg::status_type                    rsp_status,
   output logic [dscc_pkg::RAW_BITS-1:0]           rsp_raw_code,
   output logic                                    rsp_suspect,
   output logic [dscc_pkg::COUNT_BITS-1:0]         rsp_failure_count,
   output logic [dscc_pkg::OUT_BITS-1:0]           rsp_voltage_mv,
   output logic [dscc_pkg::OUT_BITS-1:0]           rsp_dust_ug_m3,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dscc_pkg::INDEX_BITS-1:0]    csr_index,
   input  wire logic [dscc_pkg::CFG_BITS-1:0]      csr_wdata
);
   import dscc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers.
   dscc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer.
   dscc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Check, counter and conversion datapath.
   dscc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .sts                (sts),
      .req_sample_led_off (req_sample_led_off),
      .req_sample_led_on  (req_sample_led_on),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_raw_code       (rsp_raw_code),
      .rsp_suspect        (rsp_suspect),
      .rsp_failure_count  (rsp_failure_count),
      .rsp_voltage_mv     (rsp_voltage_mv),
      .rsp_dust_ug_m3     (rsp_dust_ug_m3)
   );

endmodule

`default_nettype wire

### rtl/dscc_checker.sv
// Port-level checks for the dust sample check and convert block, with its bind.
// Depends on dscc_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module dscc_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire dscc_pkg::status_type               rsp_status,
   input  wire logic [dscc_pkg::RAW_BITS-1:0]      rsp_raw_code,
   input  wire logic                               rsp_suspect,
   input  wire logic [dscc_pkg::COUNT_BITS-1:0]    rsp_failure_count,
   input  wire logic [dscc_pkg::OUT_BITS-1:0]      rsp_voltage_mv,
   input  wire logic [dscc_pkg::OUT_BITS-1:0]      rsp_dust_ug_m3
);
   import dscc_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_voltage_mv) && $stable(rsp_dust_ug_m3)
         && $stable(rsp_failure_count))
      else $error("result word changed while stalled");

   // No conversion is reported unless the reading is valid.
   a_no_conv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_VALID |-> rsp_voltage_mv == '0
         && rsp_dust_ug_m3 == '0)
      else $error("conversion reported on an invalid reading");

   // A full scale error carries no sample and no suspect flag.
   a_fs_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FS_ZERO |-> rsp_raw_code == '0 && !rsp_suspect)
      else $error("full scale error word not cleared");

   // Disconnection only follows a suspect sample.
   a_disc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DISCONNECTED |-> rsp_suspect
         && rsp_failure_count != '0)
      else $error("disconnection without a suspect sample");

   // A good sample clears the failure counter.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_suspect && rsp_status == ST_VALID |-> rsp_failure_count == '0)
      else $error("failure counter not cleared by a good sample");

endmodule

bind dust_sample_check_convert_core dscc_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_raw_code      (rsp_raw_code),
   .rsp_suspect       (rsp_suspect),
   .rsp_failure_count (rsp_failure_count),
   .rsp_voltage_mv    (rsp_voltage_mv),
   .rsp_dust_ug_m3    (rsp_dust_ug_m3)
);

`default_nettype wire

### tb/dust_sample_check_convert_core_tb.sv
// Self-checking testbench for dust_sample_check_convert_core: sample words are
// predicted at acceptance and compared with every result word in order.
// Depends on dscc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module dust_sample_check_convert_core_tb;
   import dscc_pkg::*;

   localparam int CLOCK_HALF_NS = 5;
   localparam int TIMEOUT_NS = 3_000_000;
   localparam int DRAIN_CYCLES = 70;
   localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
   localparam int SETTINGS_SPAN = 30;
   localparam logic [31:0] UG_PER_MG = 32'd1000;
   localparam logic [31:0] SAT_OUT = 32'h0000_FFFF;
   localparam logic [COUNT_BITS-1:0] RUN_MAX = '1;

   // Expected content of one result word.
   typedef struct packed {
      status_type               status;
      logic [RAW_BITS-1:0]      raw_code;
      logic                     suspect;
      logic [COUNT_BITS-1:0]    failure_count;
      logic [OUT_BITS-1:0]      voltage_mv;
      logic [OUT_BITS-1:0]      dust_ug_m3;
   } reading_type;

   // Shapes of sample pair used to steer the plausibility checks.
   typedef enum int {
      KIND_GOOD,
      KIND_LOW,
      KIND_HIGH,
      KIND_CLOSE,
      KIND_NOISE
   } sample_kind_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [SAMPLE_BITS-1:0]   req_sample_led_off;
   logic [SAMPLE_BITS-1:0]   req_sample_led_on;
   logic                     rsp_valid;
   logic                     rsp_ready;
   status_type               rsp_status;
   logic [RAW_BITS-1:0]      rsp_raw_code;
   logic                     rsp_suspect;
   logic [COUNT_BITS-1:0]    rsp_failure_count;
   logic [OUT_BITS-1:0]      rsp_voltage_mv;
   logic [OUT_BITS-1:0]      rsp_dust_ug_m3;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [INDEX_BITS-1:0]    csr_index;
   logic [CFG_BITS-1:0]      csr_wdata;

   // Shadow copy of the block's registers and consecutive-failure counter.
   cfg_type                  active_settings;
   logic [COUNT_BITS-1:0]    suspect_run;
   reading_type              pending_readings[$];

   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_off_cycles;
   int  error_count;
   int  items_sent;
   int  readings_checked;
   int  settings_loaded;
   bit  offering;

   dust_sample_check_convert_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_led_off (req_sample_led_off),
      .req_sample_led_on  (req_sample_led_on),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_raw_code       (rsp_raw_code),
      .rsp_suspect        (rsp_suspect),
      .rsp_failure_count  (rsp_failure_count),
      .rsp_voltage_mv     (rsp_voltage_mv),
      .rsp_dust_ug_m3     (rsp_dust_ug_m3),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF_NS clock = ~clock;
   end

   // Hard limit on the length of the run.
   initial begin
      #TIMEOUT_NS;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic cfg_type power_on_settings();
      cfg_type s;
      s.full_scale_code = 16'd4095;
      s.reference_mv    = 16'd3300;
      s.zero_dust_mv    = 16'd600;
      s.slope_mv_per_mg = 16'd500;
      s.low_limit       = 16'd20;
      s.high_limit      = 16'd4075;
      s.min_difference  = 16'd20;
      s.failure_limit   = 8'd3;
      return s;
   endfunction

   function automatic logic [OUT_BITS-1:0] clip_to_out(input logic [31:0] q);
      return (q > SAT_OUT) ? '1 : q[OUT_BITS-1:0];
   endfunction

   // Works out the result word for one sample pair and advances the counter.
   function automatic reading_type predict_reading(input logic [SAMPLE_BITS-1:0] off,
                                                   input logic [SAMPLE_BITS-1:0] on);
      reading_type r;
      logic [SAMPLE_BITS-1:0] gap;
      logic [31:0] product;
      r = '0;
      r.status = ST_VALID;
      r.raw_code = on;
      if (active_settings.full_scale_code == '0) begin
         // No checks are made and the counter holds its value.
         r.status = ST_FS_ZERO;
         r.raw_code = '0;
      end else begin
         gap = (on > off) ? on - off : off - on;
         r.suspect = (on <= active_settings.low_limit) || (on >= active_settings.high_limit)
                     || (gap < active_settings.min_difference);
         if (r.suspect) begin
            if (suspect_run != RUN_MAX) suspect_run = suspect_run + 1'b1;
            if (suspect_run >= active_settings.failure_limit) r.status = ST_DISCONNECTED;
         end else begin
            suspect_run = '0;
         end
         if (r.status == ST_VALID) begin
            product = 32'(on) * 32'(active_settings.reference_mv);
            r.voltage_mv = clip_to_out(product / 32'(active_settings.full_scale_code));
            // The dust figure starts from the already saturated voltage.
            if (active_settings.slope_mv_per_mg != '0 &&
                r.voltage_mv > active_settings.zero_dust_mv) begin
               product = 32'(r.voltage_mv - active_settings.zero_dust_mv) * UG_PER_MG;
               r.dust_ug_m3 = clip_to_out(product / 32'(active_settings.slope_mv_per_mg));
            end
         end
      end
      r.failure_count = suspect_run;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Result side: checks every accepted word and drives rsp_ready.
   initial begin : reading_monitor
      reading_type want;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               $error("result word arrived with no reading due");
               error_count++;
            end else begin
               want = pending_readings.pop_front();
               readings_checked++;
               check_field("status", want.status, rsp_status);
               check_field("raw_code", want.raw_code, rsp_raw_code);
               check_field("suspect", want.suspect, rsp_suspect);
               check_field("failure_count", want.failure_count, rsp_failure_count);
               check_field("voltage_mv", want.voltage_mv, rsp_voltage_mv);
               check_field("dust_ug_m3", want.dust_ug_m3, rsp_dust_ug_m3);
            end
         end
         // A long hold-off, when asked for, overrides the random stalls.
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offers one sample word, waits for acceptance and records its reading.
   task automatic send_pair(input logic [SAMPLE_BITS-1:0] off,
                            input logic [SAMPLE_BITS-1:0] on);
      int idle;
      idle = 0;
      while ($urandom_range(0, 99) < send_idle_pct) idle++;
      if (idle > 0) begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 1'b0;
         end
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      offering = 1'b1;
      req_sample_led_off <= off;
      req_sample_led_on <= on;
      do @(posedge clock); while (!req_ready);
      pending_readings.push_back(predict_reading(off, on));
      items_sent++;
   endtask

   // Builds a sample pair of the given shape under the current settings.
   task automatic send_kind(input sample_kind_type kind);
      int on, off, lo, hi, md, top, d;
      lo = active_settings.low_limit;
      hi = active_settings.high_limit;
      md = active_settings.min_difference;
      on = $urandom_range(0, SAMPLE_MAX);
      off = $urandom_range(0, SAMPLE_MAX);
      case (kind)
         KIND_GOOD: begin
            top = (hi - 1 < SAMPLE_MAX) ? hi - 1 : SAMPLE_MAX;
            if (lo + 1 <= top) on = $urandom_range(lo + 1, top);
            if (on >= md && (on + md > SAMPLE_MAX || $urandom_range(0, 1) == 1)) begin
               off = $urandom_range(0, on - md);
            end else if (on + md <= SAMPLE_MAX) begin
               off = $urandom_range(on + md, SAMPLE_MAX);
            end
         end
         KIND_LOW: on = $urandom_range(0, (lo < SAMPLE_MAX) ? lo : SAMPLE_MAX);
         KIND_HIGH: on = $urandom_range((hi < SAMPLE_MAX) ? hi : SAMPLE_MAX, SAMPLE_MAX);
         KIND_CLOSE: begin
            if (md > 0) begin
               d = $urandom_range(0, (md - 1 < SAMPLE_MAX) ? md - 1 : SAMPLE_MAX);
               off = ($urandom_range(0, 1) == 1) ? on + d : on - d;
               if (off > SAMPLE_MAX) off = SAMPLE_MAX;
               if (off < 0) off = 0;
            end
         end
         default: ;
      endcase
      send_pair(SAMPLE_BITS'(off), SAMPLE_BITS'(on));
   endtask

   // Stops offering and waits until every reading has come back.
   task automatic drain_readings();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   // Writes all registers while the block is idle.
   task automatic load_settings(input cfg_type s);
      reg_index_type idx;
      logic [CFG_BITS-1:0] data;
      drain_readings();
      for (int i = 0; i < (1 << INDEX_BITS); i++) begin
         idx = reg_index_type'(i);
         case (idx)
            REG_FULL_SCALE:    data = s.full_scale_code;
            REG_REFERENCE_MV:  data = s.reference_mv;
            REG_ZERO_DUST_MV:  data = s.zero_dust_mv;
            REG_SLOPE:         data = s.slope_mv_per_mg;
            REG_LOW_LIMIT:     data = s.low_limit;
            REG_HIGH_LIMIT:    data = s.high_limit;
            REG_MIN_DIFF:      data = s.min_difference;
            // The upper byte is junk that the block must drop.
            REG_FAILURE_LIMIT: data = {8'($urandom), s.failure_limit};
            default:           data = '0;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      active_settings = s;
      settings_loaded++;
   endtask

   // Mostly plausible values, with a fifth spread over the whole register.
   function automatic logic [CFG_BITS-1:0] pick_value(input int lo, input int hi);
      if ($urandom_range(0, 4) == 0) return CFG_BITS'($urandom_range(0, 16'hFFFF));
      return CFG_BITS'($urandom_range(lo, hi));
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      s.full_scale_code = ($urandom_range(0, 19) == 0) ? '0 : pick_value(1, 8191);
      s.reference_mv    = pick_value(1000, 5000);
      s.zero_dust_mv    = pick_value(0, 1500);
      s.slope_mv_per_mg = ($urandom_range(0, 9) == 0) ? '0 : pick_value(50, 1000);
      s.low_limit       = pick_value(0, 300);
      s.high_limit      = pick_value(3500, SAMPLE_MAX);
      s.min_difference  = pick_value(0, 200);
      s.failure_limit   = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 6));
      return s;
   endfunction

   // Reset values of the registers, with good, suspect and disconnected words.
   task automatic test_reset_defaults();
      send_pair(12'd100, 12'd2000);
      send_pair(12'd4095, 12'd21);
      send_pair(12'd0, 12'd4074);
      send_pair(12'd0, 12'd0);
      send_pair(12'd4095, 12'd4095);
      send_pair(12'd2000, 12'd2010);
      send_pair(12'd0, 12'd4095);
      send_pair(12'd1000, 12'd2000);
   endtask

   // Saturation of both conversions, with extreme values in every register.
   task automatic test_conversion_extremes();
      cfg_type s;
      s.full_scale_code = 16'd1;
      s.reference_mv    = 16'hFFFF;
      s.zero_dust_mv    = 16'd0;
      s.slope_mv_per_mg = 16'd1;
      s.low_limit       = 16'd0;
      s.high_limit      = 16'hFFFF;
      s.min_difference  = 16'd0;
      s.failure_limit   = 8'hFF;
      load_settings(s);
      send_pair(12'd4095, 12'd4095);
      send_pair(12'd0, 12'd1);
      send_pair(12'd4095, 12'd0);
      s.full_scale_code = 16'hFFFF;
      s.zero_dust_mv    = 16'hFFFF;
      s.slope_mv_per_mg = 16'hFFFF;
      s.low_limit       = 16'hFFFF;
      s.min_difference  = 16'hFFFF;
      load_settings(s);
      send_pair(12'd0, 12'd4095);
      send_pair(12'd4095, 12'd4095);
   endtask

   // A zero full scale reports an error and leaves the counter alone.
   task automatic test_full_scale_zero();
      cfg_type s;
      s = power_on_settings();
      s.full_scale_code = '0;
      load_settings(s);
      send_pair(12'd0, 12'd0);
      send_pair(12'd100, 12'd2000);
   endtask

   // With a zero limit every suspect word is disconnected, no good one is.
   task automatic test_failure_limit_zero();
      cfg_type s;
      s = power_on_settings();
      s.failure_limit = '0;
      load_settings(s);
      send_pair(12'd100, 12'd2000);
      send_pair(12'd0, 12'd0);
      send_pair(12'd100, 12'd2000);
   endtask

   // A zero slope forces the dust figure to zero.
   task automatic test_slope_zero();
      cfg_type s;
      s = power_on_settings();
      s.slope_mv_per_mg = '0;
      load_settings(s);
      send_pair(12'd0, 12'd4000);
      send_pair(12'd0, 12'd100);
   endtask

   // Runs of suspect words followed by good ones, under changing settings.
   task automatic test_random_sequences(input int count);
      int sent, next_reload, run, cap;
      sent = 0;
      next_reload = 0;
      while (sent < count) begin
         if (sent >= next_reload) begin
            load_settings(random_settings());
            next_reload = sent + SETTINGS_SPAN;
         end
         cap = active_settings.failure_limit + 2;
         run = $urandom_range(0, (cap > 10) ? 10 : cap);
         repeat (run) begin
            send_kind(sample_kind_type'($urandom_range(KIND_LOW, KIND_CLOSE)));
            sent++;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_kind(KIND_NOISE);
            sent++;
         end
         repeat ($urandom_range(1, 3)) begin
            send_kind(KIND_GOOD);
            sent++;
         end
      end
   endtask

   // A long unbroken run of suspect words drives the counter to its ceiling.
   task automatic test_counter_saturation();
      cfg_type s;
      s = power_on_settings();
      s.failure_limit = '1;
      load_settings(s);
      repeat (int'(RUN_MAX) + 15) begin
         send_kind(sample_kind_type'($urandom_range(KIND_LOW, KIND_CLOSE)));
      end
      send_kind(KIND_GOOD);
   endtask

   // The receiver holds off while words keep coming, so the input must stall.
   task automatic test_output_backpressure();
      load_settings(power_on_settings());
      hold_off_cycles = 300;
      repeat (12) begin
         send_kind(($urandom_range(0, 3) == 0) ? KIND_LOW : KIND_GOOD);
      end
      drain_readings();
   endtask

   // Test sequence.
   initial begin : test_sequence
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample_led_off <= '0;
      req_sample_led_on <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_FULL_SCALE;
      csr_wdata <= '0;
      offering = 1'b0;
      hold_off_cycles = 0;
      error_count = 0;
      items_sent = 0;
      readings_checked = 0;
      settings_loaded = 0;
      active_settings = power_on_settings();
      suspect_run = '0;
      send_idle_pct = 7;
      recv_idle_pct = 60;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_conversion_extremes();
      test_full_scale_zero();
      test_failure_limit_zero();
      test_slope_zero();
      test_random_sequences(80);

      send_idle_pct = 60;
      recv_idle_pct = 7;
      test_random_sequences(80);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_sequences(80);
      test_counter_saturation();
      test_output_backpressure();

      drain_readings();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered reset values, conversion extremes, zero full scale, slope and limit,");
      $display("counter saturation and output stalls: %0d words, %0d results, %0d settings.",
               items_sent, readings_checked, settings_loaded);
      if (error_count == 0 && pending_readings.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
